### rtl/core/rmq_pkg.sv
package rmq_pkg;

  localparam int FRAC_BITS = 16;
  localparam int IN_W      = 24;
  localparam int OUT_W     = 18;
  localparam int ONE       = 1 << FRAC_BITS;

  // root component index; BR_W is the trace branch
  typedef enum logic [1:0] {
    BR_X = 2'd0,
    BR_Y = 2'd1,
    BR_Z = 2'd2,
    BR_W = 2'd3
  } branch_t;

endpackage

### rtl/core/rmq_sqrt.sv
// Pipelined integer square root, one result bit per stage (floor).
module rmq_sqrt
  import rmq_pkg::*;
#(
  parameter int IW = 48,
  parameter int SW = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_v,
  input  logic [IW-1:0]   in_x,
  input  logic [SW-1:0]   in_side,
  output logic            out_v,
  output logic [IW/2-1:0] out_root,
  output logic [SW-1:0]   out_side
);

  localparam int RW = IW / 2;

  logic          v_r      [RW];
  logic [IW-1:0] x_r      [RW];
  logic [RW+1:0] rem_r    [RW];
  logic [RW-1:0] root_r   [RW];
  logic [SW-1:0] side_r   [RW];

  logic          v_nxt    [RW];
  logic [IW-1:0] x_nxt    [RW];
  logic [RW+1:0] rem_nxt  [RW];
  logic [RW-1:0] root_nxt [RW];
  logic [SW-1:0] side_nxt [RW];

  always_comb begin
    logic [IW-1:0] x_in;
    logic [RW+1:0] rem_in;
    logic [RW-1:0] root_in;
    logic [RW+3:0] t;
    logic [RW+3:0] trial;
    logic [RW+3:0] diff;
    for (int k = 0; k < RW; k++) begin
      if (k == 0) begin
        v_nxt[k]    = in_v;
        x_in        = in_x;
        rem_in      = '0;
        root_in     = '0;
        side_nxt[k] = in_side;
      end else begin
        v_nxt[k]    = v_r[k-1];
        x_in        = x_r[k-1];
        rem_in      = rem_r[k-1];
        root_in     = root_r[k-1];
        side_nxt[k] = side_r[k-1];
      end
      x_nxt[k] = x_in;
      t        = {rem_in, x_in[IW-1-2*k -: 2]};
      trial    = {2'b00, root_in, 2'b01};
      diff     = t - trial;
      if (t >= trial) begin
        rem_nxt[k]  = diff[RW+1:0];
        root_nxt[k] = {root_in[RW-2:0], 1'b1};
      end else begin
        rem_nxt[k]  = t[RW+1:0];
        root_nxt[k] = {root_in[RW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < RW; k++) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_nxt[k];
      end
      if (en) begin
        x_r[k]    <= x_nxt[k];
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
        side_r[k] <= side_nxt[k];
      end
    end
  end

  assign out_v    = v_r[RW-1];
  assign out_root = root_r[RW-1];
  assign out_side = side_r[RW-1];

endmodule

### rtl/core/rmq_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Needs num < den * 2**QW so the quotient fits in QW bits.
module rmq_div
  import rmq_pkg::*;
#(
  parameter int NW = 40,
  parameter int DW = 24,
  parameter int QW = 17,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_v,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [SW-1:0] in_side,
  output logic          out_v,
  output logic [QW-1:0] out_quo,
  output logic [SW-1:0] out_side
);

  logic          v_r      [QW];
  logic [QW-1:0] lo_r     [QW];
  logic [DW-1:0] den_r    [QW];
  logic [DW-1:0] rem_r    [QW];
  logic [QW-1:0] quo_r    [QW];
  logic [SW-1:0] side_r   [QW];

  logic          v_nxt    [QW];
  logic [QW-1:0] lo_nxt   [QW];
  logic [DW-1:0] den_nxt  [QW];
  logic [DW-1:0] rem_nxt  [QW];
  logic [QW-1:0] quo_nxt  [QW];
  logic [SW-1:0] side_nxt [QW];

  always_comb begin
    logic [DW-1:0] rem_in;
    logic [QW-1:0] quo_in;
    logic [DW:0]   t;
    logic [DW:0]   diff;
    for (int k = 0; k < QW; k++) begin
      if (k == 0) begin
        v_nxt[k]    = in_v;
        lo_nxt[k]   = in_num[QW-1:0];
        den_nxt[k]  = in_den;
        rem_in      = DW'(in_num[NW-1:QW]);
        quo_in      = '0;
        side_nxt[k] = in_side;
      end else begin
        v_nxt[k]    = v_r[k-1];
        lo_nxt[k]   = lo_r[k-1];
        den_nxt[k]  = den_r[k-1];
        rem_in      = rem_r[k-1];
        quo_in      = quo_r[k-1];
        side_nxt[k] = side_r[k-1];
      end
      t    = {rem_in, lo_nxt[k][QW-1-k]};
      diff = t - {1'b0, den_nxt[k]};
      if (t >= {1'b0, den_nxt[k]}) begin
        rem_nxt[k] = diff[DW-1:0];
        quo_nxt[k] = {quo_in[QW-2:0], 1'b1};
      end else begin
        rem_nxt[k] = t[DW-1:0];
        quo_nxt[k] = {quo_in[QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < QW; k++) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_nxt[k];
      end
      if (en) begin
        lo_r[k]   <= lo_nxt[k];
        den_r[k]  <= den_nxt[k];
        rem_r[k]  <= rem_nxt[k];
        quo_r[k]  <= quo_nxt[k];
        side_r[k] <= side_nxt[k];
      end
    end
  end

  assign out_v    = v_r[QW-1];
  assign out_quo  = quo_r[QW-1];
  assign out_side = side_r[QW-1];

endmodule

### rtl/core/rotation_matrix_to_quaternion.sv
// Pipeline depth is set mostly by the bit-serial root pipelines (24 and 18 stages)
// and the divider banks (17 and 25 stages).
// Throughput: one matrix per cycle, every stage taking a new one, unless the output stalls.
// A stalled output freezes the whole pipeline; a one-entry skid holds the input.
// Reset (rst_n low, synchronous) clears valid bits and the skid; data is not reset.
module rotation_matrix_to_quaternion
  import rmq_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [IN_W-1:0]  in_m00,
  input  logic signed [IN_W-1:0]  in_m01,
  input  logic signed [IN_W-1:0]  in_m02,
  input  logic signed [IN_W-1:0]  in_m10,
  input  logic signed [IN_W-1:0]  in_m11,
  input  logic signed [IN_W-1:0]  in_m12,
  input  logic signed [IN_W-1:0]  in_m20,
  input  logic signed [IN_W-1:0]  in_m21,
  input  logic signed [IN_W-1:0]  in_m22,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [OUT_W-1:0] out_quat_x,
  output logic signed [OUT_W-1:0] out_quat_y,
  output logic signed [OUT_W-1:0] out_quat_z,
  output logic signed [OUT_W-1:0] out_quat_w,
  output logic                    out_degenerate
);

  localparam logic signed [19:0] ONE_A = 20'(ONE);

  logic en;
  logic in_acc;
  logic signed [IN_W-1:0] in_m [9];

  assign in_m[0] = in_m00;
  assign in_m[1] = in_m01;
  assign in_m[2] = in_m02;
  assign in_m[3] = in_m10;
  assign in_m[4] = in_m11;
  assign in_m[5] = in_m12;
  assign in_m[6] = in_m20;
  assign in_m[7] = in_m21;
  assign in_m[8] = in_m22;

  // ---------------- input skid and stage 0
  logic                   skid_v_r;
  logic signed [IN_W-1:0] skid_r [9];
  logic                   v0_r;
  logic signed [IN_W-1:0] m0_r [9];

  logic                   out_valid_r;

  assign en       = !(out_valid_r && out_stall);
  assign in_acc   = in_valid && !skid_v_r;
  assign in_stall = skid_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_v_r <= 1'b0;
      v0_r     <= 1'b0;
    end else if (en) begin
      v0_r     <= skid_v_r || in_acc;
      skid_v_r <= 1'b0;
    end else if (in_acc) begin
      skid_v_r <= 1'b1;
    end
    for (int i = 0; i < 9; i++) begin
      if (en) begin
        m0_r[i] <= skid_v_r ? skid_r[i] : in_m[i];
      end else if (in_acc) begin
        skid_r[i] <= in_m[i];
      end
    end
  end

  // ---------------- stage 1: squares
  logic        v1_r;
  logic signed [IN_W-1:0] m1_r [9];
  logic [46:0] sq1_r [9];
  logic [46:0] sq1_nxt [9];

  always_comb begin
    logic signed [47:0] p;
    for (int i = 0; i < 9; i++) begin
      p          = m0_r[i] * m0_r[i];
      sq1_nxt[i] = p[46:0];
    end
  end

  // ---------------- stage 2: row sums
  logic        v2_r;
  logic signed [IN_W-1:0] m2_r [9];
  logic [47:0] sum2_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
    if (en) begin
      for (int i = 0; i < 9; i++) begin
        m1_r[i]  <= m0_r[i];
        sq1_r[i] <= sq1_nxt[i];
        m2_r[i]  <= m1_r[i];
      end
      for (int r = 0; r < 3; r++) begin
        sum2_r[r] <= {1'b0, sq1_r[3*r]} + {1'b0, sq1_r[3*r+1]} + {1'b0, sq1_r[3*r+2]};
      end
    end
  end

  // ---------------- row lengths
  logic        rv   [3];
  logic [23:0] len  [3];
  logic [71:0] rside[3];

  for (genvar r = 0; r < 3; r++) begin : g_len
    rmq_sqrt #(.IW(48), .SW(72)) u_len (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_v     (v2_r),
      .in_x     (sum2_r[r]),
      .in_side  ({m2_r[3*r], m2_r[3*r+1], m2_r[3*r+2]}),
      .out_v    (rv[r]),
      .out_root (len[r]),
      .out_side (rside[r])
    );
  end

  // ---------------- stage 3: divider operands for normalisation
  logic        v3_r;
  logic        degen3_r;
  logic [39:0] num3_r  [9];
  logic [23:0] den3_r  [9];
  logic        sign3_r [9];

  logic        v3_nxt;
  logic        degen3_nxt;
  logic [39:0] num3_nxt  [9];
  logic [23:0] den3_nxt  [9];
  logic        sign3_nxt [9];

  always_comb begin
    logic [23:0] e;
    logic [23:0] mag;
    v3_nxt     = rv[0] && rv[1] && rv[2];
    degen3_nxt = 1'b0;
    for (int r = 0; r < 3; r++) begin
      if (len[r] == 24'd0) begin
        degen3_nxt = 1'b1;
      end
      for (int c = 0; c < 3; c++) begin
        e                  = rside[r][71-24*c -: 24];
        mag                = e[23] ? (24'd0 - e) : e;
        sign3_nxt[3*r+c]   = e[23];
        num3_nxt[3*r+c]    = {mag, 16'd0} + {17'd0, len[r][23:1]};
        den3_nxt[3*r+c]    = (len[r] == 24'd0) ? 24'd1 : len[r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v3_nxt;
    end
    if (en) begin
      degen3_r <= degen3_nxt;
      for (int i = 0; i < 9; i++) begin
        num3_r[i]  <= num3_nxt[i];
        den3_r[i]  <= den3_nxt[i];
        sign3_r[i] <= sign3_nxt[i];
      end
    end
  end

  logic        dv    [9];
  logic [16:0] nq    [9];
  logic [1:0]  dside [9];

  for (genvar i = 0; i < 9; i++) begin : g_norm
    rmq_div #(.NW(40), .DW(24), .QW(17), .SW(2)) u_norm (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_v     (v3_r),
      .in_num   (num3_r[i]),
      .in_den   (den3_r[i]),
      .in_side  ({degen3_r, sign3_r[i]}),
      .out_v    (dv[i]),
      .out_quo  (nq[i]),
      .out_side (dside[i])
    );
  end

  // ---------------- stage 4: signed normalised elements
  logic              v4_r;
  logic              degen4_r;
  logic signed [17:0] n4_r [9];
  logic              v4_nxt;
  logic              degen4_nxt;
  logic signed [17:0] n4_nxt [9];

  always_comb begin
    logic signed [17:0] qs;
    v4_nxt     = 1'b1;
    degen4_nxt = 1'b0;
    for (int i = 0; i < 9; i++) begin
      v4_nxt     = v4_nxt && dv[i];
      degen4_nxt = degen4_nxt || dside[i][1];
      qs         = $signed({1'b0, nq[i]});
      n4_nxt[i]  = dside[i][0] ? -qs : qs;
    end
  end

  // ---------------- stage 5: trace and branch pick
  logic              v5_r;
  logic              degen5_r;
  branch_t           br5_r;
  logic signed [17:0] n5_r [9];
  branch_t           br5_nxt;

  always_comb begin
    logic signed [19:0] trace;
    trace = n4_r[0] + n4_r[4] + n4_r[8];
    priority if (trace > 0) begin
      br5_nxt = BR_W;
    end else if (n4_r[0] < n4_r[4]) begin
      br5_nxt = (n4_r[4] < n4_r[8]) ? BR_Z : BR_Y;
    end else begin
      br5_nxt = (n4_r[0] < n4_r[8]) ? BR_Z : BR_X;
    end
  end

  // ---------------- stage 6: root argument and component numerators
  logic              v6_r;
  logic              degen6_r;
  branch_t           br6_r;
  logic [35:0]       x6_r;
  logic signed [18:0] da6_r, db6_r, dc6_r;

  logic signed [19:0] a6;
  logic signed [18:0] da6, db6, dc6;

  always_comb begin
    unique case (br5_r)
      BR_W: begin
        a6  = n5_r[0] + n5_r[4] + n5_r[8] + ONE_A;
        da6 = n5_r[7] - n5_r[5];
        db6 = n5_r[2] - n5_r[6];
        dc6 = n5_r[3] - n5_r[1];
      end
      BR_X: begin
        a6  = n5_r[0] - n5_r[4] - n5_r[8] + ONE_A;
        da6 = n5_r[7] - n5_r[5];
        db6 = n5_r[3] + n5_r[1];
        dc6 = n5_r[6] + n5_r[2];
      end
      BR_Y: begin
        a6  = n5_r[4] - n5_r[8] - n5_r[0] + ONE_A;
        da6 = n5_r[2] - n5_r[6];
        db6 = n5_r[7] + n5_r[5];
        dc6 = n5_r[1] + n5_r[3];
      end
      BR_Z: begin
        a6  = n5_r[8] - n5_r[0] - n5_r[4] + ONE_A;
        da6 = n5_r[3] - n5_r[1];
        db6 = n5_r[2] + n5_r[6];
        dc6 = n5_r[5] + n5_r[7];
      end
      default: begin
        a6  = '0;
        da6 = '0;
        db6 = '0;
        dc6 = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (en) begin
      v4_r <= v4_nxt;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
    if (en) begin
      degen4_r <= degen4_nxt;
      degen5_r <= degen4_r;
      br5_r    <= br5_nxt;
      for (int i = 0; i < 9; i++) begin
        n4_r[i] <= n4_nxt[i];
        n5_r[i] <= n4_r[i];
      end
      degen6_r <= degen5_r || (a6 <= 0);
      br6_r    <= br5_r;
      x6_r     <= {a6, 16'd0};
      da6_r    <= da6;
      db6_r    <= db6;
      dc6_r    <= dc6;
    end
  end

  // ---------------- quaternion root
  logic        sv;
  logic [17:0] s_root;
  logic [59:0] s_side;

  rmq_sqrt #(.IW(36), .SW(60)) u_root (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (v6_r),
    .in_x     (x6_r),
    .in_side  ({br6_r, degen6_r, da6_r, db6_r, dc6_r}),
    .out_v    (sv),
    .out_root (s_root),
    .out_side (s_side)
  );

  // ---------------- stage 7: divider operands for the other components
  logic        v7_r;
  logic [20:0] info7_r;
  logic [18:0] den7_r;
  logic [33:0] num7_r  [3];
  logic        sign7_r [3];

  always_ff @(posedge clk) begin
    logic [18:0] sp1;
    logic signed [18:0] d;
    logic [17:0] mag;
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else if (en) begin
      v7_r <= sv;
    end
    if (en) begin
      sp1     = {1'b0, s_root} + 19'd1;
      info7_r <= {s_side[59:57], sp1[18:1]};
      den7_r  <= (s_root == 18'd0) ? 19'd1 : {s_root, 1'b0};
      for (int c = 0; c < 3; c++) begin
        d          = s_side[56-19*c -: 19];
        mag        = d[18] ? 18'(-d) : 18'(d);
        sign7_r[c] <= d[18];
        num7_r[c]  <= {mag, 16'd0} + {16'd0, s_root};
      end
    end
  end

  logic        qv_a, qv_b, qv_c;
  logic [24:0] q_a, q_b, q_c;
  logic [21:0] side_a;
  logic        side_b, side_c;

  rmq_div #(.NW(34), .DW(19), .QW(25), .SW(22)) u_comp_a (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (v7_r),
    .in_num   (num7_r[0]),
    .in_den   (den7_r),
    .in_side  ({sign7_r[0], info7_r}),
    .out_v    (qv_a),
    .out_quo  (q_a),
    .out_side (side_a)
  );

  rmq_div #(.NW(34), .DW(19), .QW(25), .SW(1)) u_comp_b (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (v7_r),
    .in_num   (num7_r[1]),
    .in_den   (den7_r),
    .in_side  (sign7_r[1]),
    .out_v    (qv_b),
    .out_quo  (q_b),
    .out_side (side_b)
  );

  rmq_div #(.NW(34), .DW(19), .QW(25), .SW(1)) u_comp_c (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (v7_r),
    .in_num   (num7_r[2]),
    .in_den   (den7_r),
    .in_side  (sign7_r[2]),
    .out_v    (qv_c),
    .out_quo  (q_c),
    .out_side (side_c)
  );

  // ---------------- output stage: saturate and place components
  logic signed [OUT_W-1:0] qx_r, qy_r, qz_r, qw_r;
  logic                    degen_r;

  function automatic logic signed [17:0] sat_comp(input logic [24:0] q, input logic neg);
    logic signed [17:0] m;
    m = (q > 25'(ONE)) ? 18'(ONE) : $signed(q[17:0]);
    return neg ? -m : m;
  endfunction

  always_ff @(posedge clk) begin
    logic signed [17:0] va, vb, vc, vr;
    branch_t br;
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= qv_a && qv_b && qv_c;
    end
    if (en) begin
      va = sat_comp(q_a, side_a[21]);
      vb = sat_comp(q_b, side_b);
      vc = sat_comp(q_c, side_c);
      vr = $signed(side_a[17:0]);
      br = branch_t'(side_a[20:19]);
      degen_r <= side_a[18];
      if (side_a[18]) begin
        qx_r <= '0;
        qy_r <= '0;
        qz_r <= '0;
        qw_r <= '0;
      end else begin
        unique case (br)
          BR_W: begin
            qx_r <= va; qy_r <= vb; qz_r <= vc; qw_r <= vr;
          end
          BR_X: begin
            qx_r <= vr; qw_r <= va; qy_r <= vb; qz_r <= vc;
          end
          BR_Y: begin
            qy_r <= vr; qw_r <= va; qz_r <= vb; qx_r <= vc;
          end
          BR_Z: begin
            qz_r <= vr; qw_r <= va; qx_r <= vb; qy_r <= vc;
          end
          default: begin
            qx_r <= '0; qy_r <= '0; qz_r <= '0; qw_r <= '0;
          end
        endcase
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_quat_x     = qx_r;
  assign out_quat_y     = qy_r;
  assign out_quat_z     = qz_r;
  assign out_quat_w     = qw_r;
  assign out_degenerate = degen_r;

endmodule

### rtl/core/rmq_checker.sv
module rmq_checker
  import rmq_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic signed [OUT_W-1:0] out_quat_x,
  input logic signed [OUT_W-1:0] out_quat_y,
  input logic signed [OUT_W-1:0] out_quat_z,
  input logic signed [OUT_W-1:0] out_quat_w,
  input logic                    out_degenerate
);

  localparam logic signed [OUT_W-1:0] POS1 = OUT_W'(ONE);
  localparam logic signed [OUT_W-1:0] NEG1 = -POS1;

  // a degenerate transaction carries an all-zero quaternion
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |->
      out_quat_x == 0 && out_quat_y == 0 && out_quat_z == 0 && out_quat_w == 0)
    else $error("degenerate result with non-zero components");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      out_quat_x <= POS1 && out_quat_x >= NEG1 && out_quat_y <= POS1 && out_quat_y >= NEG1 &&
      out_quat_z <= POS1 && out_quat_z >= NEG1 && out_quat_w <= POS1 && out_quat_w >= NEG1)
    else $error("component outside unit range");

  // input back-pressure only follows a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("input stalled without output stall");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_quat_x) && $stable(out_quat_w) &&
      $stable(out_degenerate))
    else $error("stalled result changed");

endmodule

bind rotation_matrix_to_quaternion rmq_checker u_rmq_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_quat_x     (out_quat_x),
  .out_quat_y     (out_quat_y),
  .out_quat_z     (out_quat_z),
  .out_quat_w     (out_quat_w),
  .out_degenerate (out_degenerate)
);
